@@ rtl/core/ciq_pkg.sv @@
// ----------------------------------------------------------------------------
// ciq_pkg
// Shared types, widths and helper functions for the circular ID queue.
// ----------------------------------------------------------------------------
package ciq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 22;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;
  localparam int CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  head_value;
    logic              found;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  // A capacity of zero acts as one; anything above the built depth saturates.
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(i) + CNT_W'(1);
    if (n >= cap) begin
      return '0;
    end
    return n[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/ciq_req_if.sv @@
// ----------------------------------------------------------------------------
// ciq_req_if
// Request channel: an operation code and an identifier, with valid/ready.
// ----------------------------------------------------------------------------
interface ciq_req_if;
  import ciq_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [VAL_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

@@ rtl/core/ciq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ciq_rsp_if
// Response channel: status, head value, found flag and occupancy.
// ----------------------------------------------------------------------------
interface ciq_rsp_if;
  import ciq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  head_value;
  logic              found;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output head_value, output found,
                  output occupancy, input ready);
  modport sink (input valid, input status, input head_value, input found,
                input occupancy, output ready);
endinterface

@@ rtl/core/ciq_ram.sv @@
// ----------------------------------------------------------------------------
// ciq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ciq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ciq_seq.sv @@
// ----------------------------------------------------------------------------
// ciq_seq
// Queue pointers and the sequencer that walks the slot RAM for peek and search.
// ----------------------------------------------------------------------------
module ciq_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ciq_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                      req_valid,
  input  logic [ciq_pkg::OP_W-1:0]  req_opcode,
  input  logic [ciq_pkg::VAL_W-1:0] req_value,
  output logic                      req_ready,
  input  logic                      out_free,
  output logic                      res_load,
  output ciq_pkg::result_t          res,
  output logic                      ram_we,
  output logic [ciq_pkg::IDX_W-1:0] ram_waddr,
  output logic [ciq_pkg::VAL_W-1:0] ram_wdata,
  output logic [ciq_pkg::IDX_W-1:0] ram_raddr,
  input  logic [ciq_pkg::VAL_W-1:0] ram_rdata
);
  import ciq_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cap;
  logic [IDX_W-1:0] scan_idx;
  logic [CNT_W-1:0] scan_left;
  logic [VAL_W-1:0] key;
  status_t          res_status;
  logic [VAL_W-1:0] res_head;
  logic             res_found;
  logic [CNT_W-1:0] flush_cap;
  logic             accept;
  logic             hit;
  logic             is_full;
  logic             is_empty;

  assign flush_cap = eff_cap(cfg_wdata);
  assign accept    = req_valid && (state == S_IDLE);
  assign hit       = (ram_rdata == key);
  assign is_full   = (count >= cap);
  assign is_empty  = (count == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (op_t'(req_opcode))
            OP_PEEK:   state_next = is_empty ? S_DONE : S_PEEK;
            OP_SEARCH: state_next = is_empty ? S_DONE : S_SCAN;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_PEEK: state_next = S_DONE;
      S_SCAN: begin
        if (hit || (scan_left == '0)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == S_IDLE);
    res_load  = (state == S_DONE) && out_free;
    ram_we    = accept && (op_t'(req_opcode) == OP_ENQ) && !is_full;
    ram_waddr = next_slot(tail, cap);
    ram_wdata = req_value;
    ram_raddr = (state == S_IDLE) ? head : scan_idx;
    res.status     = res_status;
    res.head_value = res_head;
    res.found      = res_found;
    res.occupancy  = OCC_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      cap   <= eff_cap(CAP_RESET);
      tail  <= IDX_W'(eff_cap(CAP_RESET) - CNT_W'(1));
    end else if (cfg_we) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      cap   <= flush_cap;
      tail  <= IDX_W'(flush_cap - CNT_W'(1));
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            key        <= req_value;
            res_status <= STAT_OK;
            res_head   <= '0;
            res_found  <= 1'b0;
            scan_idx   <= next_slot(head, cap);
            scan_left  <= count - CNT_W'(1);
            unique case (op_t'(req_opcode))
              OP_ENQ: begin
                if (is_full) begin
                  res_status <= STAT_FULL;
                end else begin
                  tail  <= ram_waddr;
                  count <= count + CNT_W'(1);
                end
              end
              OP_DEQ: begin
                if (is_empty) begin
                  res_status <= STAT_EMPTY;
                end else begin
                  head  <= next_slot(head, cap);
                  count <= count - CNT_W'(1);
                end
              end
              OP_PEEK: begin
                if (is_empty) begin
                  res_status <= STAT_EMPTY;
                end
              end
              default: ;
            endcase
          end
        end
        S_PEEK: res_head <= ram_rdata;
        S_SCAN: begin
          if (hit) begin
            res_found <= 1'b1;
          end else if (scan_left != '0) begin
            scan_idx  <= next_slot(scan_idx, cap);
            scan_left <= scan_left - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/circular_id_queue_with_search.sv @@
// Enqueue and dequeue go from idle to done; a nonempty peek passes through the peek
// state, and a nonempty search scans k entries (k is at most the occupancy).
// One request is in flight at a time; the next is taken once the result is registered.
// A search reads one slot per cycle through the single read port of the slot RAM.
// Reset clears the pointers and count and sets the capacity to 64; the slot RAM is
// not cleared, and the block takes requests from the first cycle after reset.
// ----------------------------------------------------------------------------
// circular_id_queue_with_search
// Ring-buffer queue of identifiers with enqueue, dequeue, peek and search.
// ----------------------------------------------------------------------------
module circular_id_queue_with_search (
  input  logic                      clk,
  input  logic                      rst,
  ciq_req_if.sink                   req,
  ciq_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [ciq_pkg::CAP_W-1:0] cfg_wdata
);
  import ciq_pkg::*;

  logic             out_valid;
  result_t          out_res;
  logic             out_free;
  logic             res_load;
  result_t          res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  assign out_free = !out_valid || rsp.ready;

  ciq_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_value  (req.value),
    .req_ready  (req.ready),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  ciq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = STAT_W'(out_res.status);
  assign rsp.head_value = out_res.head_value;
  assign rsp.found      = out_res.found;
  assign rsp.occupancy  = out_res.occupancy;

endmodule

@@ rtl/core/ciq_checker.sv @@
// ----------------------------------------------------------------------------
// ciq_checker
// Port-level checks on the response channel of the circular ID queue.
// ----------------------------------------------------------------------------
module ciq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [ciq_pkg::STAT_W-1:0] rsp_status,
  input logic [ciq_pkg::VAL_W-1:0]  rsp_head_value,
  input logic                       rsp_found,
  input logic [ciq_pkg::OCC_W-1:0]  rsp_occupancy
);
  import ciq_pkg::*;

  // A stalled response holds its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_head_value) && $stable(rsp_found) && $stable(rsp_occupancy))
    else $error("response changed while stalled");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp_occupancy) <= DEPTH))
    else $error("occupancy above depth");

  // A refused enqueue leaves a nonempty queue and reports nothing else.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_FULL) |->
      (rsp_occupancy != '0) && !rsp_found && (rsp_head_value == '0))
    else $error("inconsistent full response");

  // An empty response means no entries are held and no value is reported.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_EMPTY) |->
      (rsp_occupancy == '0) && !rsp_found && (rsp_head_value == '0))
    else $error("inconsistent empty response");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> (rsp_status == STAT_OK) && (rsp_occupancy != '0))
    else $error("found reported without held entries");

endmodule

bind circular_id_queue_with_search ciq_checker u_ciq_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_head_value (rsp.head_value),
  .rsp_found      (rsp.found),
  .rsp_occupancy  (rsp.occupancy)
);

@@ test/id_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_queue_checker
// Watches the request, response and capacity ports of the circular ID queue.
// It keeps its own copy of the ring and predicts each response, then
// compares the responses in order and counts the mismatches.
// ----------------------------------------------------------------------------
module id_queue_checker (
  input  logic                      clk,
  input  logic                      rst,
  ciq_req_if                        req,
  ciq_rsp_if                        rsp,
  input  logic                      cfg_we,
  input  logic [ciq_pkg::CAP_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        outstanding
);
  import ciq_pkg::*;

  logic [VAL_W-1:0] slots [DEPTH];
  logic [IDX_W-1:0] head_at;
  logic [IDX_W-1:0] tail_at;
  logic [CNT_W-1:0] held;
  logic [CAP_W-1:0] cap_setting;
  result_t          awaited_results [$];

  function automatic logic [CNT_W-1:0] usable_slots(input logic [CAP_W-1:0] setting);
    if (setting == '0) begin
      return CNT_W'(1);
    end
    if (int'(setting) > DEPTH) begin
      return CNT_W'(DEPTH);
    end
    return CNT_W'(setting);
  endfunction

  function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] lim);
    return (int'(idx) + 1 >= int'(lim)) ? '0 : idx + 1'b1;
  endfunction

  function void clear_ring();
    head_at = '0;
    held    = '0;
    tail_at = IDX_W'(usable_slots(cap_setting) - 1'b1);
  endfunction

  function result_t serve_request(input op_t op, input logic [VAL_W-1:0] v);
    result_t          r;
    logic [CNT_W-1:0] lim;
    logic [IDX_W-1:0] idx;
    int               k;
    r   = '0;
    lim = usable_slots(cap_setting);
    if (int'(head_at) >= int'(lim)) head_at = '0;
    if (int'(tail_at) >= int'(lim)) tail_at = IDX_W'(lim - 1'b1);
    if (held > lim) held = lim;
    case (op)
      OP_ENQ: begin
        if (held >= lim) begin
          r.status = STAT_FULL;
        end else begin
          tail_at = step_index(tail_at, lim);
          slots[tail_at] = v;
          held = held + 1'b1;
        end
      end
      OP_DEQ: begin
        if (held == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          held = held - 1'b1;
          head_at = step_index(head_at, lim);
        end
      end
      OP_PEEK: begin
        if (held == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.head_value = slots[head_at];
        end
      end
      default: begin
        idx = head_at;
        for (k = 0; k < int'(held); k++) begin
          if (slots[idx] == v) begin
            r.found = 1'b1;
            break;
          end
          idx = step_index(idx, lim);
        end
      end
    endcase
    r.occupancy = OCC_W'(held);
    return r;
  endfunction

  task automatic compare_response(input result_t want);
    if (rsp.status !== want.status) begin
      $error("status expected %0d got %0d", want.status, rsp.status);
      mismatches++;
    end
    if (rsp.head_value !== want.head_value) begin
      $error("head_value expected %0h got %0h", want.head_value, rsp.head_value);
      mismatches++;
    end
    if (rsp.found !== want.found) begin
      $error("found expected %0d got %0d", want.found, rsp.found);
      mismatches++;
    end
    if (rsp.occupancy !== want.occupancy) begin
      $error("occupancy expected %0d got %0d", want.occupancy, rsp.occupancy);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      cap_setting = CAP_RESET;
      clear_ring();
      awaited_results.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          compare_response(awaited_results.pop_front());
        end
      end
      if (cfg_we === 1'b1) begin
        cap_setting = cfg_wdata;
        clear_ring();
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        awaited_results.push_back(serve_request(op_t'(req.opcode), req.value));
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

@@ test/circular_id_queue_with_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_id_queue_with_search_tb
// Drives enqueue, dequeue, peek and search requests through the circular ID
// queue under several capacity settings, with random stalls on both sides.
// A directed opening covers empty, full, wrap and flush cases; biased random
// phases then fill and drain the ring while the checker predicts each result.
// ----------------------------------------------------------------------------
module circular_id_queue_with_search_tb;
  import ciq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic             steady;
  int               mismatches;
  int               outstanding;
  int               cycles = 0;
  logic [VAL_W-1:0] id_pool [6];
  logic [VAL_W-1:0] newest_id;

  ciq_req_if req ();
  ciq_rsp_if rsp ();

  circular_id_queue_with_search uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  id_queue_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp.ready <= steady || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_id(input int pool_pct);
    if ($urandom_range(99) < pool_pct) begin
      return id_pool[$urandom_range(5)];
    end
    return VAL_W'($urandom);
  endfunction

  task automatic send_request(input op_t op, input logic [VAL_W-1:0] v);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid  <= 1'b1;
    req.opcode <= op;
    req.value  <= v;
    do @(posedge clk); while (req.ready !== 1'b1);
    if (op == OP_ENQ) newest_id = v;
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] c, input int count);
    int               room;
    int               seg_left;
    int               r;
    int               i;
    logic             filling;
    op_t              op;
    logic [VAL_W-1:0] v;
    room = (c == '0) ? 1 : ((int'(c) > DEPTH) ? DEPTH : int'(c));
    write_capacity(c);
    filling  = 1'b1;
    seg_left = $urandom_range(room, 2 * room + 4);
    for (i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        filling  = !filling;
        seg_left = $urandom_range(room, 2 * room + 4);
      end
      seg_left--;
      r = $urandom_range(99);
      if (r < (filling ? 70 : 15)) begin
        op = OP_ENQ;
      end else if (r < (filling ? 78 : 60)) begin
        op = OP_DEQ;
      end else if (r < (filling ? 88 : 78)) begin
        op = OP_PEEK;
      end else begin
        op = OP_SEARCH;
      end
      if (op == OP_SEARCH && $urandom_range(3) == 0) begin
        v = newest_id;
      end else begin
        v = pick_id((op == OP_SEARCH) ? 60 : 40);
      end
      send_request(op, v);
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    steady     = 1'b0;
    req.valid  = 1'b0;
    req.opcode = OP_ENQ;
    req.value  = '0;
    rsp.ready  = 1'b0;
    newest_id  = '0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = VAL_W'($urandom);
    id_pool[3] = VAL_W'($urandom);
    id_pool[4] = VAL_W'($urandom);
    id_pool[5] = VAL_W'($urandom);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(OP_PEEK, '0);
    send_request(OP_DEQ, '0);
    send_request(OP_SEARCH, '0);
    send_request(OP_ENQ, 22'h000000);
    send_request(OP_ENQ, 22'h3FFFFF);
    send_request(OP_ENQ, 22'h2AAAAA);
    send_request(OP_ENQ, 22'h155555);
    send_request(OP_PEEK, '0);
    send_request(OP_SEARCH, 22'h3FFFFF);
    send_request(OP_SEARCH, 22'h155555);
    send_request(OP_SEARCH, 22'h0ABCDE);
    send_request(OP_DEQ, '0);
    send_request(OP_PEEK, '0);
    send_request(OP_DEQ, '0);
    send_request(OP_DEQ, '0);

    // A capacity write with an entry still held must empty the queue.
    write_capacity(7'd2);
    send_request(OP_PEEK, '0);
    send_request(OP_ENQ, 22'h001234);
    send_request(OP_ENQ, 22'h3FFFFF);
    send_request(OP_ENQ, 22'h000007);
    send_request(OP_SEARCH, 22'h3FFFFF);
    send_request(OP_DEQ, '0);
    send_request(OP_ENQ, 22'h2ABCDE);
    send_request(OP_SEARCH, 22'h2ABCDE);
    send_request(OP_PEEK, '0);

    run_phase(7'd1, 125);
    run_phase(7'd0, 125);
    run_phase(7'd127, 125);
    steady = 1'b1;
    run_phase(7'd64, 125);
    steady = 1'b0;
    run_phase(7'd2, 125);
    run_phase(7'd64, 125);
    run_phase(7'd5, 125);
    run_phase(CAP_W'($urandom_range(1, 127)), 125);
    run_phase(7'd17, 125);

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
